>>> sv/multi_channel_ring_buffer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the multi-channel ring buffer
// Property wrappers that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_RING_BUFFER_ASSERT_SVH
`define MULTI_CHANNEL_RING_BUFFER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on aclk and held off during reset.
`define MCRB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("multi_channel_ring_buffer: assertion failed");
// Next-cycle implication.
`define MCRB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("multi_channel_ring_buffer: assertion failed");
`else
`define MCRB_ASSERT_IMP(lbl, ante, cons)
`define MCRB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> sv/mcrb_pkg.sv
// ---------------------------------------------------------------------------
// Multi-channel ring buffer package
// Operation and status codes, reset constants and the lane command type.
// ---------------------------------------------------------------------------
package mcrb_pkg;

    typedef enum logic [1:0] {
        FN_CREATE = 2'd0,
        FN_WRITE  = 2'd1,
        FN_READ   = 2'd2,
        FN_CLOSE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_BAD    = 3'd1,
        ST_NOFREE = 3'd2,
        ST_FULL   = 3'd3,
        ST_BLOCK  = 3'd4
    } status_t;

    localparam logic [7:0] HANDLE_BASE_RST = 8'd100;

    // Command broadcast to every byte lane; fields are sized for the largest
    // configuration and each lane uses the low bits it needs.
    typedef struct packed {
        logic        wr;
        logic        rd;
        logic [2:0]  bank;
        logic [15:0] row;
        logic [7:0]  chan;
        logic [3:0]  cnt;
    } lane_cmd_t;

endpackage

>>> sv/mcrb_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, registered read data.
// ---------------------------------------------------------------------------
module mcrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

>>> sv/mcrb_lane.sv
// ---------------------------------------------------------------------------
// Byte lane of the ring store
// Works out which byte of a transfer falls on this bank and where it lives.
// ---------------------------------------------------------------------------
module mcrb_lane
    import mcrb_pkg::*;
#(
    parameter int CHANNELS = 32,
    parameter int LANES    = 8,
    parameter int ROWS     = 512,
    parameter int LANE_IDX = 0
) (
    input  logic        aclk,
    input  lane_cmd_t   cmd,
    input  logic [63:0] wbytes,
    output logic [7:0]  q
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RW = $clog2(ROWS);
    localparam int AW = $clog2(CHANNELS * ROWS);

    logic [4:0]    off_raw;
    logic [4:0]    off;
    logic          active;
    logic [RW-1:0] row_base;
    logic [RW-1:0] row_sel;
    logic [AW-1:0] addr;
    logic [7:0]    wbyte;

    always_comb begin
        // Position of this bank within the transfer, modulo the lane count.
        off_raw = 5'(LANE_IDX) + 5'(LANES) - 5'(cmd.bank);
        off     = (off_raw >= 5'(LANES)) ? off_raw - 5'(LANES) : off_raw;
        active  = off < 5'(cmd.cnt);
        row_base = cmd.row[RW-1:0];
        // Banks below the start bank hold the bytes that spill into the next row.
        if (5'(LANE_IDX) < 5'(cmd.bank)) begin
            row_sel = (row_base == RW'(ROWS - 1)) ? '0 : row_base + RW'(1);
        end else begin
            row_sel = row_base;
        end
        addr  = AW'(AW'(cmd.chan[CW-1:0]) * AW'(ROWS)) + AW'(row_sel);
        wbyte = wbytes[off[2:0]*8 +: 8];
    end

    mcrb_ram #(
        .WIDTH(8),
        .DEPTH(CHANNELS * ROWS)
    ) u_ram (
        .aclk (aclk),
        .we   (cmd.wr & active),
        .re   (cmd.rd & active),
        .addr (addr),
        .wdata(wbyte),
        .rdata(q)
    );

endmodule

>>> sv/multi_channel_ring_buffer.sv
// ---------------------------------------------------------------------------
// Multi-channel ring buffer
// A table of byte FIFO channels with create, write, read and close requests.
// ---------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser carries the operation and s_tdata
// the handle, caller identity, up to eight bytes and a byte count. Each request
// produces exactly one response transfer on the m_ stream carrying a status,
// the new handle of a create, the bytes read and the number of bytes moved.
// The handle base register is written through cfg_wr_en / cfg_wr_data; the
// user must do so only while the block is idle, which the block does not enforce.
// A request passes from acceptance to a valid response by looking the channel
// up in the table, then updating the channel state and driving the byte lanes,
// then merging the lane read data into the response register. One request is
// in flight at a time and the input is ready again in the cycle after the
// response is loaded, so the block takes no new request until the last one is
// through.
// Reset frees every channel and restores the handle base to 100; the byte
// store itself is not cleared and needs no clearing pass.
// When the receiver stalls, the response waits in the output register; the
// next request may still be accepted and runs until its own response is due,
// then waits for the output register to empty.
// ---------------------------------------------------------------------------
module multi_channel_ring_buffer
    import mcrb_pkg::*;
#(
    parameter int CHANNELS   = 32,
    parameter int RING_BYTES = 4096,
    parameter int LANES      = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: handle base.
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] handle, [23:8] caller_id, [87:24] write_bytes, [91:88] byte_count,
    // [95:92] zero.
    input  logic [95:0] s_tdata,
    // [1:0] func.
    input  logic [1:0]  s_tuser,
    // Response stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [10:3] new_handle, [74:11] read_bytes, [78:75] done_count,
    // [79] zero.
    output logic [79:0] m_tdata
);

    `include "multi_channel_ring_buffer_assert.svh"

    localparam int ROWS = (RING_BYTES + LANES - 1) / LANES;
    localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FW   = $clog2(RING_BYTES);
    localparam int RW   = $clog2(ROWS);
    localparam int BW   = (LANES > 1) ? $clog2(LANES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_ACT,
        S_FIN
    } state_t;

    state_t state_reg;

    logic [7:0] base_reg;

    // Channel table. Storage cursors (bank, row) run independently of the
    // ring position, which only matters through the fill count.
    logic          in_use_reg [CHANNELS];
    logic [15:0]   owner_reg  [CHANNELS];
    logic [FW-1:0] fill_reg   [CHANNELS];
    logic [BW-1:0] wbank_reg  [CHANNELS];
    logic [RW-1:0] wrow_reg   [CHANNELS];
    logic [BW-1:0] rbank_reg  [CHANNELS];
    logic [RW-1:0] rrow_reg   [CHANNELS];

    // Captured request.
    func_t       func_reg;
    logic [7:0]  handle_reg;
    logic [15:0] caller_reg;
    logic [63:0] wbytes_reg;
    logic [3:0]  cnt_reg;

    // Lookup results.
    logic [CW-1:0] chan_reg;
    logic          hit_reg;
    logic          own_eq_reg;
    logic [FW-1:0] fill_lk_reg;
    logic [BW-1:0] wbank_lk_reg;
    logic [RW-1:0] wrow_lk_reg;
    logic [BW-1:0] rbank_lk_reg;
    logic [RW-1:0] rrow_lk_reg;
    logic          free_ok_reg;
    logic [CW-1:0] free_idx_reg;

    // Response held between the update and the merge.
    status_t     res_status_reg;
    logic [7:0]  res_nh_reg;
    logic [3:0]  res_done_reg;
    logic        res_rd_reg;

    logic        m_tvalid_reg;
    logic [79:0] m_tdata_reg;

    // Lookup and free-channel search.
    logic [7:0]    lk_idx;
    logic [CW-1:0] lk_chan;
    logic          lk_hit;
    logic          free_ok;
    logic [CW-1:0] free_idx;

    always_comb begin
        lk_idx  = handle_reg - base_reg;
        lk_chan = lk_idx[CW-1:0];
        lk_hit  = ({1'b0, lk_idx} < 9'(CHANNELS)) && in_use_reg[lk_chan];
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                free_ok  = 1'b1;
                free_idx = CW'(i);
            end
        end
    end

    // Outcome of the request.
    logic [FW-1:0] space;
    logic [FW-1:0] cnt_ext;
    logic [FW-1:0] n_wr;
    logic [FW-1:0] n_rd;
    logic          wr_go;
    logic          rd_go;
    logic          close_go;
    logic          create_go;
    status_t       act_status;
    logic [3:0]    act_done;
    logic [7:0]    act_nh;
    logic [BW-1:0] cur_bank;
    logic [RW-1:0] cur_row;
    logic [4:0]    adv_sum;
    logic [BW-1:0] adv_bank;
    logic [RW-1:0] adv_row;

    always_comb begin
        cnt_ext = FW'(cnt_reg);
        space   = FW'(RING_BYTES - 1) - fill_lk_reg;
        n_wr    = (cnt_ext < space) ? cnt_ext : space;
        n_rd    = (cnt_ext < fill_lk_reg) ? cnt_ext : fill_lk_reg;
        wr_go     = 1'b0;
        rd_go     = 1'b0;
        close_go  = 1'b0;
        create_go = 1'b0;
        act_status = ST_OK;
        act_done   = '0;
        act_nh     = '0;
        unique case (func_reg)
            FN_CREATE: begin
                if (free_ok_reg) begin
                    create_go = 1'b1;
                    act_nh    = base_reg + 8'(free_idx_reg);
                end else begin
                    act_status = ST_NOFREE;
                end
            end
            FN_WRITE: begin
                if (cnt_reg != 4'd0) begin
                    if (!hit_reg) begin
                        act_status = ST_BAD;
                    end else if (n_wr == '0) begin
                        act_status = ST_FULL;
                    end else begin
                        wr_go    = 1'b1;
                        act_done = n_wr[3:0];
                    end
                end
            end
            FN_READ: begin
                if (cnt_reg != 4'd0) begin
                    if (!hit_reg) begin
                        act_status = ST_BAD;
                    end else if (fill_lk_reg == '0) begin
                        act_status = ST_BLOCK;
                    end else begin
                        rd_go    = 1'b1;
                        act_done = n_rd[3:0];
                    end
                end
            end
            FN_CLOSE: begin
                if (!hit_reg) begin
                    act_status = ST_BAD;
                end else begin
                    close_go = own_eq_reg;
                end
            end
            default: act_status = ST_BAD;
        endcase
        // Cursor advance for whichever direction moves data.
        cur_bank = wr_go ? wbank_lk_reg : rbank_lk_reg;
        cur_row  = wr_go ? wrow_lk_reg : rrow_lk_reg;
        adv_sum  = 5'(cur_bank) + 5'(act_done);
        if (adv_sum >= 5'(LANES)) begin
            adv_bank = BW'(adv_sum - 5'(LANES));
            adv_row  = (cur_row == RW'(ROWS - 1)) ? '0 : cur_row + RW'(1);
        end else begin
            adv_bank = BW'(adv_sum);
            adv_row  = cur_row;
        end
    end

    // Byte lanes.
    lane_cmd_t  lane_cmd;
    logic [7:0] lane_q [LANES];

    always_comb begin
        lane_cmd.wr   = (state_reg == S_ACT) && wr_go;
        lane_cmd.rd   = (state_reg == S_ACT) && rd_go;
        lane_cmd.bank = 3'(cur_bank);
        lane_cmd.row  = 16'(cur_row);
        lane_cmd.chan = 8'(chan_reg);
        lane_cmd.cnt  = act_done;
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        mcrb_lane #(
            .CHANNELS(CHANNELS),
            .LANES   (LANES),
            .ROWS    (ROWS),
            .LANE_IDX(k)
        ) u_lane (
            .aclk  (aclk),
            .cmd   (lane_cmd),
            .wbytes(wbytes_reg),
            .q     (lane_q[k])
        );
    end

    // Merge: rotate the lane outputs back into request order and blank the
    // lanes beyond the count, and all lanes when the request was not a read.
    logic [63:0]   merged;
    logic [4:0]    sel_raw;
    logic [BW-1:0] sel;

    always_comb begin
        merged  = '0;
        sel_raw = '0;
        sel     = '0;
        for (int i = 0; i < LANES; i++) begin
            sel_raw = 5'(rbank_lk_reg) + 5'(i);
            sel = (sel_raw >= 5'(LANES)) ? BW'(sel_raw - 5'(LANES)) : BW'(sel_raw);
            if (res_rd_reg && (5'(i) < 5'(res_done_reg))) begin
                merged[i*8 +: 8] = lane_q[sel];
            end
        end
    end

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    // Control, request capture and response register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            base_reg     <= HANDLE_BASE_RST;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
            // A new response replaces the one leaving in the same cycle.
            if (state_reg == S_FIN && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK: state_reg <= S_ACT;
                S_ACT:  state_reg <= S_FIN;
                S_FIN: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
        if (state_reg == S_IDLE && s_tvalid) begin
            func_reg   <= func_t'(s_tuser);
            handle_reg <= s_tdata[7:0];
            caller_reg <= s_tdata[23:8];
            wbytes_reg <= s_tdata[87:24];
            cnt_reg    <= (s_tdata[91:88] > 4'(LANES)) ? 4'(LANES) : s_tdata[91:88];
        end
        if (state_reg == S_LOOK) begin
            chan_reg     <= lk_chan;
            hit_reg      <= lk_hit;
            own_eq_reg   <= owner_reg[lk_chan] == caller_reg;
            fill_lk_reg  <= fill_reg[lk_chan];
            wbank_lk_reg <= wbank_reg[lk_chan];
            wrow_lk_reg  <= wrow_reg[lk_chan];
            rbank_lk_reg <= rbank_reg[lk_chan];
            rrow_lk_reg  <= rrow_reg[lk_chan];
            free_ok_reg  <= free_ok;
            free_idx_reg <= free_idx;
        end
        if (state_reg == S_ACT) begin
            res_status_reg <= act_status;
            res_nh_reg     <= act_nh;
            res_done_reg   <= act_done;
            res_rd_reg     <= rd_go;
        end
        if (state_reg == S_FIN && out_free) begin
            m_tdata_reg <= {1'b0, res_done_reg, merged, res_nh_reg, res_status_reg};
        end
    end

    // Channel table updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                in_use_reg[i] <= 1'b0;
            end
        end else if (state_reg == S_ACT) begin
            if (create_go) begin
                in_use_reg[free_idx_reg] <= 1'b1;
            end
            if (close_go) begin
                in_use_reg[chan_reg] <= 1'b0;
            end
        end
        if (state_reg == S_ACT) begin
            if (create_go) begin
                owner_reg[free_idx_reg] <= caller_reg;
                fill_reg[free_idx_reg]  <= '0;
                wbank_reg[free_idx_reg] <= '0;
                wrow_reg[free_idx_reg]  <= '0;
                rbank_reg[free_idx_reg] <= '0;
                rrow_reg[free_idx_reg]  <= '0;
            end
            if (wr_go) begin
                fill_reg[chan_reg]  <= fill_lk_reg + FW'(act_done);
                wbank_reg[chan_reg] <= adv_bank;
                wrow_reg[chan_reg]  <= adv_row;
            end
            if (rd_go) begin
                fill_reg[chan_reg]  <= fill_lk_reg - FW'(act_done);
                rbank_reg[chan_reg] <= adv_bank;
                rrow_reg[chan_reg]  <= adv_row;
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A failed request never reports moved bytes or read data.
    `MCRB_ASSERT_IMP(a_err_moves_nothing, m_tvalid && (m_tdata[2:0] != ST_OK), m_tdata[78:11] == '0)
    // No request moves more bytes than there are lanes.
    `MCRB_ASSERT_IMP(a_done_bounded, m_tvalid, m_tdata[78:75] <= 4'(LANES))
    // The update cycle is always followed by the merge cycle.
    `MCRB_ASSERT_NEXT(a_act_then_fin, state_reg == S_ACT, state_reg == S_FIN)
    // Data only moves in the update cycle of a write or read.
    `MCRB_ASSERT_IMP(a_lane_only_in_act, lane_cmd.wr || lane_cmd.rd, state_reg == S_ACT && (func_reg == FN_WRITE || func_reg == FN_READ))

endmodule
